/* sv/ddmw_pkg.sv */
`default_nettype none
package ddmw_pkg;

  localparam int ELAPSED_WIDTH = 16;
  localparam int TIMEOUT_WIDTH = 16;
  localparam int CMP_WIDTH     = (ELAPSED_WIDTH > TIMEOUT_WIDTH) ? ELAPSED_WIDTH
                                                                 : TIMEOUT_WIDTH;

  localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = TIMEOUT_WIDTH'(500);

  localparam logic OP_DRIVE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic signed [9:0] SPEED_MAX = 10'sd100;
  localparam logic signed [9:0] SPEED_MIN = -10'sd100;

  // duty = mag * 255 / 100 as mag * 2.55 in fixed point, exact for mag up to 100
  localparam int               DUTY_SHIFT = 12;
  localparam logic [20:0]      DUTY_RECIP = 21'd10445;

  typedef struct packed {
    logic       in_a;
    logic       in_b;
    logic [7:0] duty;
  } side_t;

  function automatic logic signed [7:0] clamp_speed(input logic signed [9:0] v);
    logic signed [7:0] r;
    if (v > SPEED_MAX) begin
      r = 8'(SPEED_MAX);
    end else if (v < SPEED_MIN) begin
      r = 8'(SPEED_MIN);
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] duty_of(input logic [6:0] mag);
    logic [20:0] prod;
    prod = 21'(mag) * DUTY_RECIP;
    return prod[DUTY_SHIFT+7:DUTY_SHIFT];
  endfunction

endpackage
`default_nettype wire

/* sv/ddmw_mix.sv */
`default_nettype none
module ddmw_mix import ddmw_pkg::*; (
  input  wire logic signed [7:0] stick_x,
  input  wire logic signed [7:0] stick_y,
  output side_t                  left,
  output side_t                  right,
  output logic                   moving
);

  logic signed [9:0] x_ext;
  logic signed [9:0] y_ext;
  logic signed [7:0] left_speed;
  logic signed [7:0] right_speed;
  logic        [7:0] left_abs;
  logic        [7:0] right_abs;

  assign x_ext = {{2{stick_x[7]}}, stick_x};
  assign y_ext = {{2{stick_y[7]}}, stick_y};

  assign left_speed  = clamp_speed(x_ext - y_ext);
  assign right_speed = clamp_speed(-y_ext - x_ext);

  // clamped speeds stay within +-100, so the magnitude fits in 7 bits
  assign left_abs  = left_speed[7]  ? 8'(-left_speed)  : 8'(left_speed);
  assign right_abs = right_speed[7] ? 8'(-right_speed) : 8'(right_speed);

  always_comb begin
    left.in_a  = !left_speed[7] && (left_speed != 8'sd0);
    left.in_b  = left_speed[7];
    left.duty  = duty_of(left_abs[6:0]);
    right.in_a = !right_speed[7] && (right_speed != 8'sd0);
    right.in_b = right_speed[7];
    right.duty = duty_of(right_abs[6:0]);
  end

  assign moving = (left_speed != 8'sd0) || (right_speed != 8'sd0);

endmodule
`default_nettype wire

/* sv/differential_drive_mixer_watchdog_core.sv */
// differential drive mixer with command watchdog
// input channel (in_valid / in_stall): operation selects a drive command (stick_x,
// stick_y) or a one millisecond tick; stick fields are ignored on ticks
// output channel (out_valid / out_stall): bridge direction bits and duties per side,
// drive_active and timed_out; an item gives zero or one transaction
// cfg_write / cfg_data load timeout_ticks; the user must do so only while the
// block is idle, as the block itself does not enforce it
// an accepted item waits in the input register; its result is then registered
// throughput: one item per cycle while the result is not stalled, set by the single
// input register feeding the mixer and watchdog counter into the result register
// a stalled result holds; while it waits the input register cannot hand its item
// on, so in_stall rises as soon as the input register is full
// reset (rst, synchronous) stops the drive, clears the elapsed counter, empties
// both registers and loads timeout_ticks with 500
`default_nettype none
module differential_drive_mixer_watchdog_core import ddmw_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [TIMEOUT_WIDTH-1:0] cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     operation,
  input  wire logic signed [7:0]        stick_x,
  input  wire logic signed [7:0]        stick_y,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          left_in_a,
  output logic                          left_in_b,
  output logic [7:0]                    left_duty,
  output logic                          right_in_a,
  output logic                          right_in_b,
  output logic [7:0]                    right_duty,
  output logic                          drive_active,
  output logic                          timed_out
);

  logic [TIMEOUT_WIDTH-1:0] timeout_reg;

  logic                     s1_valid;
  logic                     s1_op;
  logic signed [7:0]        s1_x;
  logic signed [7:0]        s1_y;

  logic                     running;
  logic                     running_next;
  logic [ELAPSED_WIDTH-1:0] elapsed;
  logic [ELAPSED_WIDTH-1:0] elapsed_next;
  logic [ELAPSED_WIDTH-1:0] elapsed_inc;

  side_t                    mix_left;
  side_t                    mix_right;
  logic                     mix_moving;

  logic                     advance;
  logic                     emit;
  side_t                    res_left;
  side_t                    res_right;
  logic                     res_active;
  logic                     res_timed_out;

  ddmw_mix u_mix (
    .stick_x (s1_x),
    .stick_y (s1_y),
    .left    (mix_left),
    .right   (mix_right),
    .moving  (mix_moving)
  );

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_reg <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      timeout_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_op <= operation;
      s1_x  <= stick_x;
      s1_y  <= stick_y;
    end
  end

  // saturating count up
  assign elapsed_inc = (elapsed == {ELAPSED_WIDTH{1'b1}}) ? elapsed
                                                          : elapsed + 1'b1;

  always_comb begin
    emit          = 1'b0;
    running_next  = running;
    elapsed_next  = elapsed;
    res_left      = mix_left;
    res_right     = mix_right;
    res_active    = mix_moving;
    res_timed_out = 1'b0;
    if (s1_op == OP_DRIVE) begin
      // stop request while already stopped is dropped
      if (mix_moving || running) begin
        emit         = 1'b1;
        running_next = mix_moving;
        elapsed_next = '0;
      end
    end else if (running) begin
      elapsed_next = elapsed_inc;
      if (CMP_WIDTH'(elapsed_inc) >= CMP_WIDTH'(timeout_reg)) begin
        emit          = 1'b1;
        running_next  = 1'b0;
        res_left      = '0;
        res_right     = '0;
        res_active    = 1'b0;
        res_timed_out = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      elapsed <= '0;
    end else if (advance) begin
      running <= running_next;
      elapsed <= elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      left_in_a    <= res_left.in_a;
      left_in_b    <= res_left.in_b;
      left_duty    <= res_left.duty;
      right_in_a   <= res_right.in_a;
      right_in_b   <= res_right.in_b;
      right_duty   <= res_right.duty;
      drive_active <= res_active;
      timed_out    <= res_timed_out;
    end
  end

endmodule
`default_nettype wire

/* dv/tb_differential_drive_mixer_watchdog_core.sv */
module tb_differential_drive_mixer_watchdog_core;
  import ddmw_pkg::*;

  localparam int WHEEL_LIMIT   = 100;
  localparam int DUTY_FULL     = 255;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 4000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic       fwd;
    logic       rev;
    logic [7:0] duty;
  } wheel_t;

  typedef struct packed {
    wheel_t left;
    wheel_t right;
    logic   active;
    logic   tripped;
  } motor_cmd_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [TIMEOUT_WIDTH-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     operation = OP_DRIVE;
  logic signed [7:0]        stick_x = '0;
  logic signed [7:0]        stick_y = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     left_in_a;
  logic                     left_in_b;
  logic [7:0]               left_duty;
  logic                     right_in_a;
  logic                     right_in_b;
  logic [7:0]               right_duty;
  logic                     drive_active;
  logic                     timed_out;

  // drive state mirrored from the accepted transactions
  logic                     drv_running = 1'b0;
  logic [ELAPSED_WIDTH-1:0] drv_elapsed = '0;
  logic [TIMEOUT_WIDTH-1:0] drv_timeout = TIMEOUT_RESET;

  motor_cmd_t pending_cmds[$];
  int         mismatches = 0;
  int         quiet_cycles = 0;
  int         sent_items = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;

  differential_drive_mixer_watchdog_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .stick_x      (stick_x),
    .stick_y      (stick_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_in_a    (left_in_a),
    .left_in_b    (left_in_b),
    .left_duty    (left_duty),
    .right_in_a   (right_in_a),
    .right_in_b   (right_in_b),
    .right_duty   (right_duty),
    .drive_active (drive_active),
    .timed_out    (timed_out)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // clamp a mixed speed and turn it into bridge bits and a truncated duty
  function automatic wheel_t wheel_of(input int speed);
    wheel_t w;
    int     mag;
    if (speed > WHEEL_LIMIT) begin
      speed = WHEEL_LIMIT;
    end else if (speed < -WHEEL_LIMIT) begin
      speed = -WHEEL_LIMIT;
    end
    mag = (speed < 0) ? -speed : speed;
    w.fwd = (speed > 0);
    w.rev = (speed < 0);
    w.duty = 8'(mag * DUTY_FULL / WHEEL_LIMIT);
    return w;
  endfunction

  task automatic predict_drive(input logic op, input logic signed [7:0] x,
                               input logic signed [7:0] y);
    motor_cmd_t cmd;
    logic       produce;
    cmd = '0;
    produce = 1'b0;
    if (op == OP_DRIVE) begin
      cmd.left = wheel_of(int'(x) - int'(y));
      cmd.right = wheel_of(-int'(y) - int'(x));
      // centered stick while already stopped is swallowed
      if (cmd.left.duty != 0 || cmd.right.duty != 0 || cmd.left.fwd || cmd.left.rev ||
          cmd.right.fwd || cmd.right.rev || drv_running) begin
        drv_running = cmd.left.fwd | cmd.left.rev | cmd.right.fwd | cmd.right.rev;
        drv_elapsed = '0;
        cmd.active = drv_running;
        produce = 1'b1;
      end
    end else if (drv_running) begin
      if (drv_elapsed != '1) begin
        drv_elapsed++;
      end
      if (drv_elapsed >= drv_timeout) begin
        drv_running = 1'b0;
        cmd = '0;
        cmd.tripped = 1'b1;
        produce = 1'b1;
      end
    end
    if (produce) begin
      pending_cmds.push_back(cmd);
    end
  endtask

  task automatic send_item(input logic op, input logic signed [7:0] x,
                           input logic signed [7:0] y);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    stick_x <= x;
    stick_y <= y;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sent_items++;
    predict_drive(op, x, y);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) begin
      send_item(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  // drain everything in flight, including items that give no transaction
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_WIDTH-1:0] ticks);
    wait_quiet();
    cfg_write <= 1'b1;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_write <= 1'b0;
    drv_timeout = ticks;
  endtask

  task automatic test_default_timeout();
    send_ticks(1);
    send_item(OP_DRIVE, 8'sd0, 8'sd0);
    send_item(OP_DRIVE, 8'sd0, 8'sh80);
    send_ticks(500);
    send_ticks(1);
  endtask

  task automatic test_mixing();
    write_timeout(16'd3);
    send_item(OP_DRIVE, 8'sh7f, 8'sh7f);
    send_item(OP_DRIVE, 8'sh80, 8'sh80);
    send_item(OP_DRIVE, 8'sh7f, 8'sh80);
    send_item(OP_DRIVE, 8'sh80, 8'sh7f);
    send_item(OP_DRIVE, 8'sd1, 8'sd0);
    send_item(OP_DRIVE, 8'sd0, -8'sd1);
    send_item(OP_DRIVE, -8'sd1, 8'sd0);
    send_item(OP_DRIVE, 8'sd50, -8'sd50);
    send_item(OP_DRIVE, -8'sd50, -8'sd50);
    send_item(OP_DRIVE, 8'sd49, 8'sd50);
    send_item(OP_DRIVE, 8'sd0, 8'sd0);
    send_item(OP_DRIVE, 8'sd0, 8'sd0);
  endtask

  task automatic test_watchdog();
    write_timeout(16'd1);
    send_item(OP_DRIVE, 8'sd20, -8'sd30);
    send_ticks(2);
    write_timeout(16'd4);
    send_item(OP_DRIVE, -8'sd70, 8'sd10);
    send_ticks(2);
    send_item(OP_DRIVE, 8'sd5, 8'sd5);
    send_ticks(4);
    send_item(OP_DRIVE, 8'sd0, 8'sd0);
    write_timeout(16'd0);
    send_item(OP_DRIVE, 8'sd0, 8'sd100);
    send_ticks(2);
  endtask

  task automatic run_phase(input int idle, input int stall, input int target);
    int first;
    int burst;
    idle_pct = idle;
    stall_pct = stall;
    write_timeout(16'($urandom_range(1, 12)));
    first = sent_items;
    while (sent_items - first < target) begin
      case ($urandom_range(0, 9))
        0: send_item(OP_DRIVE, 8'sd0, 8'sd0);
        1: send_item(OP_DRIVE, $urandom_range(0, 1) ? 8'sh7f : 8'sh80,
                     $urandom_range(0, 1) ? 8'sh7f : 8'sh80);
        2: send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        default: send_item(OP_DRIVE, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
      endcase
      // tick bursts run from none up to two past the timeout, so most end short of it
      burst = $urandom_range(0, int'(drv_timeout) + 2);
      send_ticks(burst);
    end
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, 30);
    run_phase(77, 0, 30);
    run_phase(0, 77, 30);
    run_phase(7, 7, 30);
  endtask

  always @(posedge clk) begin : check_results
    motor_cmd_t seen;
    motor_cmd_t want;
    if (!rst && out_valid && !out_stall) begin
      seen.left = '{left_in_a, left_in_b, left_duty};
      seen.right = '{right_in_a, right_in_b, right_duty};
      seen.active = drive_active;
      seen.tripped = timed_out;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected transaction: L %b%b %0d R %b%b %0d active %b timeout %b",
                   seen.left.fwd, seen.left.rev, seen.left.duty, seen.right.fwd,
                   seen.right.rev, seen.right.duty, seen.active, seen.tripped);
        end
      end else begin
        want = pending_cmds.pop_front();
        if (seen.left !== want.left || seen.right !== want.right ||
            seen.active !== want.active || seen.tripped !== want.tripped) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch: expected L %b%b %0d R %b%b %0d active %b timeout %b",
                     want.left.fwd, want.left.rev, want.left.duty, want.right.fwd,
                     want.right.rev, want.right.duty, want.active, want.tripped);
            $display("          actual   L %b%b %0d R %b%b %0d active %b timeout %b",
                     seen.left.fwd, seen.left.rev, seen.left.duty, seen.right.fwd,
                     seen.right.rev, seen.right.duty, seen.active, seen.tripped);
          end
        end
      end
    end
  end

  // ends a hung run: no transaction on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_differential_drive_mixer_watchdog_core failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_default_timeout();
    test_mixing();
    test_watchdog();
    test_random_traffic();
    wait_quiet();
    if (mismatches == 0) begin
      $display("tb_differential_drive_mixer_watchdog_core passed");
    end else begin
      $display("tb_differential_drive_mixer_watchdog_core failed");
    end
    $finish;
  end

endmodule

/* differential_drive_mixer_watchdog_core.f */
sv/ddmw_pkg.sv
sv/ddmw_mix.sv
sv/differential_drive_mixer_watchdog_core.sv
dv/tb_differential_drive_mixer_watchdog_core.sv
